// ----- hw/rtl/cdad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_pkg: shared types and calendar helpers
// Widths, status codes, controller states, command/status bundles and the
// month-length and cumulative-day tables used by the date adder.
// ----------------------------------------------------------------------------
package cdad_pkg;

  localparam int OFFSET_BITS = 13;
  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_IN_W   = 14;
  localparam int DOY_W       = 9;

  localparam int YEAR_MAX    = 9999;
  localparam int LEAP_CYCLE  = 400;
  // Years the walk can move away from the start, rounded up.
  localparam int YEAR_SPAN   = (1 << (OFFSET_BITS - 1)) / 365 + 2;
  // Signed working year, wide enough for the walk on either side.
  localparam int YEAR_W      = $clog2(YEAR_MAX + YEAR_SPAN + 1) + 1;
  // Signed working day count: day of month plus the offset.
  localparam int DVAL_W      = OFFSET_BITS + 2;
  localparam int YMOD_W      = $clog2(LEAP_CYCLE);

  // Year mod 400 by restoring subtraction of 400 << k, k from MOD_STEPS-1 down.
  localparam int MOD_STEPS   = 6;
  localparam int STEP_W      = $clog2(MOD_STEPS);

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_CHECK,
    S_WALK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic check;
    logic walk;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mod_last;
    logic date_bad;
    logic walk_done;
    logic out_free;
  } sts_t;

  // Leap test on the year reduced mod 400.
  function automatic logic is_leap_mod(input logic [YMOD_W-1:0] r);
    return (r[1:0] == 2'd0) && (r != YMOD_W'(100)) && (r != YMOD_W'(200)) &&
           (r != YMOD_W'(300));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                                len = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:             len = DAY_W'(30);
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
      4'd12:                               len = DAY_W'(31);
      default:                             len = '0;
    endcase
    return len;
  endfunction

  // Days before the first of month m in a common year.
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] c;
    unique case (m)
      4'd1:    c = DOY_W'(0);
      4'd2:    c = DOY_W'(31);
      4'd3:    c = DOY_W'(59);
      4'd4:    c = DOY_W'(90);
      4'd5:    c = DOY_W'(120);
      4'd6:    c = DOY_W'(151);
      4'd7:    c = DOY_W'(181);
      4'd8:    c = DOY_W'(212);
      4'd9:    c = DOY_W'(243);
      4'd10:   c = DOY_W'(273);
      4'd11:   c = DOY_W'(304);
      4'd12:   c = DOY_W'(334);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/cdad_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_in_if: input channel
// Starting date and signed day offset with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cdad_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [cdad_pkg::DAY_W-1:0]               day;
  logic [cdad_pkg::MONTH_W-1:0]             month;
  logic [cdad_pkg::YEAR_IN_W-1:0]           year;
  logic signed [cdad_pkg::OFFSET_BITS-1:0]  offset_days;

  modport source (output valid, day, month, year, offset_days, input ready);
  modport sink   (input valid, day, month, year, offset_days, output ready);
endinterface

// ----- hw/rtl/cdad_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_out_if: result channel
// Result date, day of year, leap flag and status with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cdad_out_if;
  logic                             valid;
  logic                             ready;
  logic [cdad_pkg::DAY_W-1:0]       new_day;
  logic [cdad_pkg::MONTH_W-1:0]     new_month;
  logic [cdad_pkg::YEAR_IN_W-1:0]   new_year;
  logic [cdad_pkg::DOY_W-1:0]       day_of_year;
  logic                             leap_year;
  cdad_pkg::status_t                status;

  modport source (output valid, new_day, new_month, new_year, day_of_year,
                  leap_year, status, input ready);
  modport sink   (input valid, new_day, new_month, new_year, day_of_year,
                  leap_year, status, output ready);
endinterface

// ----- hw/rtl/cdad_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_ctrl: sequencing state machine
// Steps one item through year reduction, date check, month walk (valid dates only) and output.
// ----------------------------------------------------------------------------
module cdad_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cdad_pkg::sts_t sts,
  output cdad_pkg::cmd_t cmd
);

  cdad_pkg::state_t state_r;
  cdad_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdad_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cdad_pkg::S_IDLE: begin
        if (in_valid) state_nxt = cdad_pkg::S_MOD;
      end
      cdad_pkg::S_MOD: begin
        if (sts.mod_last) state_nxt = cdad_pkg::S_CHECK;
      end
      cdad_pkg::S_CHECK: begin
        state_nxt = sts.date_bad ? cdad_pkg::S_FINISH : cdad_pkg::S_WALK;
      end
      cdad_pkg::S_WALK: begin
        if (sts.walk_done) state_nxt = cdad_pkg::S_FINISH;
      end
      cdad_pkg::S_FINISH: begin
        if (sts.out_free) state_nxt = cdad_pkg::S_IDLE;
      end
      default: state_nxt = cdad_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      cdad_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      cdad_pkg::S_MOD:    cmd.mod_step = 1'b1;
      cdad_pkg::S_CHECK:  cmd.check    = 1'b1;
      cdad_pkg::S_WALK:   cmd.walk     = 1'b1;
      cdad_pkg::S_FINISH: cmd.emit     = sts.out_free;
      default: ;
    endcase
  end

  // The walk only ever ends by moving on to the output stage.
  a_walk_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cdad_pkg::S_WALK) |=>
      (state_r == cdad_pkg::S_WALK) || (state_r == cdad_pkg::S_FINISH))
    else $error("walk left to an unexpected state");

endmodule

// ----- hw/rtl/cdad_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_dp: date datapath
// Year mod 400 reduction, input date check, month-by-month walk, day-of-year
// sum and the output register.
// ----------------------------------------------------------------------------
module cdad_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  cdad_pkg::cmd_t                          cmd,
  output cdad_pkg::sts_t                          sts,
  input  logic [cdad_pkg::DAY_W-1:0]              in_day,
  input  logic [cdad_pkg::MONTH_W-1:0]            in_month,
  input  logic [cdad_pkg::YEAR_IN_W-1:0]          in_year,
  input  logic signed [cdad_pkg::OFFSET_BITS-1:0] in_offset,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [cdad_pkg::DAY_W-1:0]              out_day,
  output logic [cdad_pkg::MONTH_W-1:0]            out_month,
  output logic [cdad_pkg::YEAR_IN_W-1:0]          out_year,
  output logic [cdad_pkg::DOY_W-1:0]              out_doy,
  output logic                                    out_leap,
  output cdad_pkg::status_t                       out_status
);

  localparam int DW = cdad_pkg::DVAL_W;
  localparam int YW = cdad_pkg::YEAR_W;
  localparam int MW = cdad_pkg::YMOD_W;
  localparam int RW = cdad_pkg::YEAR_IN_W;

  logic signed [DW-1:0]                   d_r, d_nxt;
  logic [cdad_pkg::MONTH_W-1:0]           m_r, m_nxt;
  logic signed [YW-1:0]                   y_r, y_nxt;
  logic [MW-1:0]                          ymod_r, ymod_nxt;
  logic [RW-1:0]                          yrem_r, yrem_nxt;
  logic [cdad_pkg::STEP_W-1:0]            step_r, step_nxt;
  logic signed [cdad_pkg::OFFSET_BITS-1:0] off_r, off_nxt;
  logic                                   bad_r, bad_nxt;

  logic                                   out_valid_r, out_valid_nxt;
  logic [cdad_pkg::DAY_W-1:0]             oday_r, oday_nxt;
  logic [cdad_pkg::MONTH_W-1:0]           omon_r, omon_nxt;
  logic [cdad_pkg::YEAR_IN_W-1:0]         oyear_r, oyear_nxt;
  logic [cdad_pkg::DOY_W-1:0]             odoy_r, odoy_nxt;
  logic                                   oleap_r, oleap_nxt;
  cdad_pkg::status_t                      ostat_r, ostat_nxt;

  // Reduction step
  logic [RW-1:0]                          sub_val;
  // Date check
  logic                                   chk_leap;
  logic [cdad_pkg::DAY_W-1:0]             chk_len;
  logic                                   date_bad;
  // Walk
  logic                                   cur_leap;
  logic [cdad_pkg::DAY_W-1:0]             cur_len;
  logic                                   go_fwd, go_bwd;
  logic                                   wrap_fwd, wrap_bwd;
  logic [cdad_pkg::MONTH_W-1:0]           m_prev;
  logic [MW-1:0]                          ymod_prev;
  logic [cdad_pkg::DAY_W-1:0]             prev_len;
  // Result
  logic [cdad_pkg::DOY_W-1:0]             doy_val;

  function automatic logic [cdad_pkg::MONTH_W-1:0] MONTH_ONE();
    return cdad_pkg::MONTH_W'(1);
  endfunction

  assign sub_val  = RW'(cdad_pkg::LEAP_CYCLE) << step_r;

  assign chk_leap = cdad_pkg::is_leap_mod(yrem_r[MW-1:0]);
  assign chk_len  = cdad_pkg::month_len(m_r, chk_leap);
  assign date_bad = (m_r < cdad_pkg::MONTH_JAN) || (m_r > cdad_pkg::MONTH_DEC) ||
                    (y_r > YW'(cdad_pkg::YEAR_MAX)) || (d_r < DW'(1)) ||
                    (d_r > $signed(DW'(chk_len)));

  assign cur_leap = cdad_pkg::is_leap_mod(ymod_r);
  assign cur_len  = cdad_pkg::month_len(m_r, cur_leap);
  assign go_fwd   = d_r > $signed(DW'(cur_len));
  assign go_bwd   = d_r < DW'(1);
  assign wrap_fwd = (m_r == cdad_pkg::MONTH_DEC);
  assign wrap_bwd = (m_r == cdad_pkg::MONTH_JAN);

  always_comb begin
    m_prev    = wrap_bwd ? cdad_pkg::MONTH_DEC : m_r - MONTH_ONE();
    ymod_prev = ymod_r;
    if (wrap_bwd) begin
      ymod_prev = (ymod_r == '0) ? MW'(cdad_pkg::LEAP_CYCLE - 1) : ymod_r - MW'(1);
    end
    prev_len  = cdad_pkg::month_len(m_prev, cdad_pkg::is_leap_mod(ymod_prev));
  end

  assign doy_val = cdad_pkg::cum_days(m_r) +
                   cdad_pkg::DOY_W'(cur_leap && (m_r > cdad_pkg::MONTH_FEB)) +
                   cdad_pkg::DOY_W'(d_r[cdad_pkg::DAY_W-1:0] - cdad_pkg::DAY_W'(1));

  always_comb begin
    d_nxt    = d_r;
    m_nxt    = m_r;
    y_nxt    = y_r;
    ymod_nxt = ymod_r;
    yrem_nxt = yrem_r;
    step_nxt = step_r;
    off_nxt  = off_r;
    bad_nxt  = bad_r;

    if (cmd.load) begin
      d_nxt    = $signed(DW'(in_day));
      m_nxt    = in_month;
      y_nxt    = $signed(YW'(in_year));
      yrem_nxt = in_year;
      step_nxt = cdad_pkg::STEP_W'(cdad_pkg::MOD_STEPS - 1);
      off_nxt  = in_offset;
    end

    if (cmd.mod_step) begin
      if (yrem_r >= sub_val) yrem_nxt = yrem_r - sub_val;
      step_nxt = step_r - cdad_pkg::STEP_W'(1);
    end

    if (cmd.check) begin
      ymod_nxt = yrem_r[MW-1:0];
      bad_nxt  = date_bad;
      if (!date_bad) d_nxt = d_r + DW'(off_r);
    end

    if (cmd.walk) begin
      if (go_fwd) begin
        d_nxt = d_r - $signed(DW'(cur_len));
        m_nxt = wrap_fwd ? cdad_pkg::MONTH_JAN : m_r + MONTH_ONE();
        if (wrap_fwd) begin
          y_nxt    = y_r + YW'(1);
          ymod_nxt = (ymod_r == MW'(cdad_pkg::LEAP_CYCLE - 1)) ? '0 : ymod_r + MW'(1);
        end
      end else if (go_bwd) begin
        d_nxt    = d_r + $signed(DW'(prev_len));
        m_nxt    = m_prev;
        ymod_nxt = ymod_prev;
        if (wrap_bwd) y_nxt = y_r - YW'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    oday_nxt      = oday_r;
    omon_nxt      = omon_r;
    oyear_nxt     = oyear_r;
    odoy_nxt      = odoy_r;
    oleap_nxt     = oleap_r;
    ostat_nxt     = ostat_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      oday_nxt      = d_r[cdad_pkg::DAY_W-1:0];
      omon_nxt      = m_r;
      oleap_nxt     = cur_leap;
      if (bad_r) begin
        oyear_nxt = y_r[RW-1:0];
        odoy_nxt  = '0;
        ostat_nxt = cdad_pkg::ST_INVALID;
      end else begin
        odoy_nxt = doy_val;
        priority if (y_r < YW'(0)) begin
          oyear_nxt = '0;
          ostat_nxt = cdad_pkg::ST_RANGE;
        end else if (y_r > YW'(cdad_pkg::YEAR_MAX)) begin
          oyear_nxt = RW'(cdad_pkg::YEAR_MAX);
          ostat_nxt = cdad_pkg::ST_RANGE;
        end else begin
          oyear_nxt = y_r[RW-1:0];
          ostat_nxt = cdad_pkg::ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r     <= d_nxt;
    m_r     <= m_nxt;
    y_r     <= y_nxt;
    ymod_r  <= ymod_nxt;
    yrem_r  <= yrem_nxt;
    step_r  <= step_nxt;
    off_r   <= off_nxt;
    bad_r   <= bad_nxt;
    oday_r  <= oday_nxt;
    omon_r  <= omon_nxt;
    oyear_r <= oyear_nxt;
    odoy_r  <= odoy_nxt;
    oleap_r <= oleap_nxt;
    ostat_r <= ostat_nxt;
  end

  assign sts.mod_last  = (step_r == '0);
  assign sts.date_bad  = date_bad;
  assign sts.walk_done = !go_fwd && !go_bwd;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_day    = oday_r;
  assign out_month  = omon_r;
  assign out_year   = oyear_r;
  assign out_doy    = odoy_r;
  assign out_leap   = oleap_r;
  assign out_status = ostat_r;

  // Year residue and month stay in range through the walk.
  a_ymod_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> (ymod_r < MW'(cdad_pkg::LEAP_CYCLE)))
    else $error("year residue out of range during walk");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> (m_r >= cdad_pkg::MONTH_JAN) && (m_r <= cdad_pkg::MONTH_DEC))
    else $error("month out of range during walk");

  // A walked result never has day zero or a day of year beyond 365.
  a_out_day: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (ostat_r != cdad_pkg::ST_INVALID)) |->
      (oday_r != '0) && (odoy_r <= cdad_pkg::DOY_W'(365)))
    else $error("walked result has a bad day");

endmodule

// ----- hw/rtl/calendar_date_add_days_top.sv -----
`timescale 1ns / 1ps
// One item is processed at a time; the month-walk loop in the datapath sets the rate.
// A result waiting in the output register does not block the next input beat.
// Synchronous active-low reset clears control only.
// ----------------------------------------------------------------------------
// calendar_date_add_days_top: Gregorian date plus signed day offset
// Controller and datapath joined by command/status bundles; valid/ready
// channels on both sides.
// ----------------------------------------------------------------------------
module calendar_date_add_days_top (
  input logic       clk,
  input logic       rst_n,
  cdad_in_if.sink   in_ch,
  cdad_out_if.source out_ch
);

  cdad_pkg::cmd_t cmd;
  cdad_pkg::sts_t sts;
  logic           ready;

  assign in_ch.ready = ready;

  cdad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdad_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_day     (in_ch.day),
    .in_month   (in_ch.month),
    .in_year    (in_ch.year),
    .in_offset  (in_ch.offset_days),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_day    (out_ch.new_day),
    .out_month  (out_ch.new_month),
    .out_year   (out_ch.new_year),
    .out_doy    (out_ch.day_of_year),
    .out_leap   (out_ch.leap_year),
    .out_status (out_ch.status)
  );

endmodule

// ----- tb/calendar_date_add_days_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_add_days_top_test: self-checking bench for the date adder
// Drives dates and signed offsets through the input channel with random
// source and sink stalls. Every accepted beat is turned into an expected
// result by a local calendar walk, and each result beat is checked against
// the oldest pending one. Covers calendar edges, invalid dates, years leaving
// 0..9999, a long sink hold-off and a final stretch with no stalls.
// ----------------------------------------------------------------------------
module calendar_date_add_days_top_test;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [cdad_pkg::DAY_W-1:0]     new_day;
    logic [cdad_pkg::MONTH_W-1:0]   new_month;
    logic [cdad_pkg::YEAR_IN_W-1:0] new_year;
    logic [cdad_pkg::DOY_W-1:0]     day_of_year;
    logic                           leap_year;
    cdad_pkg::status_t              status;
  } date_result_t;

  logic clk = 1'b0;
  logic rst_n;

  cdad_in_if  in_ch ();
  cdad_out_if out_ch ();

  calendar_date_add_days_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  date_result_t pending_dates[$];
  int           mismatches   = 0;
  int           cycle_count  = 0;
  bit           src_idle_en  = 1'b1;
  bit           sink_idle_en = 1'b1;
  int           sink_hold    = 0;

  // --------------------------------------------------------------------------
  // Calendar predictor
  // --------------------------------------------------------------------------
  function automatic bit leap_of(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(input int m, input int y);
    case (m)
      2:                             return leap_of(y) ? 29 : 28;
      4, 6, 9, 11:                   return 30;
      1, 3, 5, 7, 8, 10, 12:         return 31;
      default:                       return 0;
    endcase
  endfunction

  function automatic date_result_t add_days(
    input logic [cdad_pkg::DAY_W-1:0]              day_in,
    input logic [cdad_pkg::MONTH_W-1:0]            month_in,
    input logic [cdad_pkg::YEAR_IN_W-1:0]          year_in,
    input logic signed [cdad_pkg::OFFSET_BITS-1:0] off_in
  );
    date_result_t r;
    int d, m, y, off, doy, clamped;
    d   = day_in;
    m   = month_in;
    y   = year_in;
    off = off_in;
    if (m < 1 || m > 12 || y > cdad_pkg::YEAR_MAX || d < 1 ||
        d > days_in_month(m, y)) begin
      r.new_day     = day_in;
      r.new_month   = month_in;
      r.new_year    = year_in;
      r.day_of_year = '0;
      r.leap_year   = leap_of(y);
      r.status      = cdad_pkg::ST_INVALID;
      return r;
    end
    d += off;
    while (d > days_in_month(m, y)) begin
      d -= days_in_month(m, y);
      m++;
      if (m > 12) begin
        m = 1;
        y++;
      end
    end
    while (d < 1) begin
      m--;
      if (m < 1) begin
        m = 12;
        y--;
      end
      d += days_in_month(m, y);
    end
    doy = d - 1;
    for (int i = 1; i < m; i++) doy += days_in_month(i, y);
    // year saturates, the rest describes the unclamped date
    clamped  = (y < 0) ? 0 : (y > cdad_pkg::YEAR_MAX) ? cdad_pkg::YEAR_MAX : y;
    r.new_day     = cdad_pkg::DAY_W'(d);
    r.new_month   = cdad_pkg::MONTH_W'(m);
    r.new_year    = cdad_pkg::YEAR_IN_W'(clamped);
    r.day_of_year = cdad_pkg::DOY_W'(doy);
    r.leap_year   = leap_of(y);
    r.status      = (clamped != y) ? cdad_pkg::ST_RANGE : cdad_pkg::ST_OK;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Beat monitors and checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    date_result_t got, want;
    bit           bad;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_dates.size());
      $display("calendar_date_add_days_top: mismatch");
      $finish;
    end
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.new_day     = out_ch.new_day;
      got.new_month   = out_ch.new_month;
      got.new_year    = out_ch.new_year;
      got.day_of_year = out_ch.day_of_year;
      got.leap_year   = out_ch.leap_year;
      got.status      = out_ch.status;
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: d=%0d m=%0d y=%0d doy=%0d leap=%0d st=%0d",
                   got.new_day, got.new_month, got.new_year, got.day_of_year,
                   got.leap_year, got.status);
      end else begin
        want = pending_dates.pop_front();
        bad  = (got.new_day !== want.new_day) || (got.new_month !== want.new_month) ||
               (got.new_year !== want.new_year) ||
               (got.day_of_year !== want.day_of_year) ||
               (got.leap_year !== want.leap_year) || (got.status !== want.status);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: exp d=%0d m=%0d y=%0d doy=%0d leap=%0d st=%0d",
                      " | got d=%0d m=%0d y=%0d doy=%0d leap=%0d st=%0d"},
                     want.new_day, want.new_month, want.new_year, want.day_of_year,
                     want.leap_year, want.status, got.new_day, got.new_month,
                     got.new_year, got.day_of_year, got.leap_year, got.status);
        end
      end
    end
    if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
      pending_dates = {pending_dates, add_days(in_ch.day, in_ch.month, in_ch.year,
                                               in_ch.offset_days)};
  end

  // Sink: random stall bursts, or a long hold-off when requested
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        for (int n = 0; n < sink_hold; n++) @(posedge clk);
        sink_hold = 0;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Source helpers
  // --------------------------------------------------------------------------
  task automatic send_date(input logic [cdad_pkg::DAY_W-1:0]              d,
                           input logic [cdad_pkg::MONTH_W-1:0]            m,
                           input logic [cdad_pkg::YEAR_IN_W-1:0]          y,
                           input logic signed [cdad_pkg::OFFSET_BITS-1:0] off);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.day         <= d;
    in_ch.month       <= m;
    in_ch.year        <= y;
    in_ch.offset_days <= off;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // Drop valid and wait for every pending result
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_date(input bit near_limits);
    int m, y, d, off;
    m = $urandom_range(1, 12);
    if (near_limits)
      y = $urandom_range(0, 1) ? $urandom_range(0, 12)
                               : $urandom_range(9987, cdad_pkg::YEAR_MAX);
    else begin
      case ($urandom_range(0, 9))
        0:       y = $urandom_range(0, 30);
        1:       y = $urandom_range(9970, cdad_pkg::YEAR_MAX);
        2:       y = 100 * $urandom_range(0, 99);
        default: y = $urandom_range(0, cdad_pkg::YEAR_MAX);
      endcase
    end
    d = $urandom_range(1, days_in_month(m, y));
    case ($urandom_range(0, 5))
      0:       off = $urandom_range(0, 80) - 40;
      1:       off = $urandom_range(0, 1) ? $urandom_range(4000, 4095)
                                          : -$urandom_range(4000, 4096);
      default: off = $urandom_range(0, (1 << cdad_pkg::OFFSET_BITS) - 1);
    endcase
    send_date(cdad_pkg::DAY_W'(d), cdad_pkg::MONTH_W'(m), cdad_pkg::YEAR_IN_W'(y),
              cdad_pkg::OFFSET_BITS'(off));
  endtask

  task automatic send_noise_date();
    send_date(cdad_pkg::DAY_W'($urandom), cdad_pkg::MONTH_W'($urandom),
              cdad_pkg::YEAR_IN_W'($urandom), cdad_pkg::OFFSET_BITS'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_calendar_edges();
    send_date(5'd15, 4'd6, 14'd2024, 13'sd0);           // zero offset
    send_date(5'd31, 4'd12, 14'd2023, 13'sd1);          // year rollover forward
    send_date(5'd1, 4'd1, 14'd2024, -13'sd1);           // year rollover backward
    send_date(5'd29, 4'd2, 14'd2000, 13'sd365);         // leap by 400 rule
    send_date(5'd29, 4'd2, 14'd1900, 13'sd0);           // century, not leap: invalid
    send_date(5'd28, 4'd2, 14'd2100, 13'sd1);
    send_date(5'd28, 4'd2, 14'd2024, 13'sd1);
    send_date(5'd1, 4'd3, 14'd2023, -13'sd1);
    send_date(5'd31, 4'd4, 14'd2020, 13'sd5);           // day past month length
    send_date(5'd0, 4'd5, 14'd2020, 13'sd5);            // day zero
    send_date(5'd10, 4'd0, 14'd2020, 13'sd5);           // month zero
    send_date(5'd10, 4'd13, 14'd2020, 13'sd5);
    send_date(5'd31, 4'd15, 14'd16383, -13'sd4096);
    send_date(5'd1, 4'd1, 14'd10000, 13'sd1);           // year above range: invalid
    send_date(5'd31, 4'd12, 14'd9999, 13'sd0);
    send_date(5'd31, 4'd12, 14'd9999, 13'sd1);          // leaves range upward
    send_date(5'd31, 4'd12, 14'd9999, 13'sd4095);
    send_date(5'd1, 4'd1, 14'd0, -13'sd1);              // leaves range downward
    send_date(5'd1, 4'd1, 14'd0, -13'sd4096);
    send_date(5'd1, 4'd1, 14'd0, 13'sd4095);
    send_date(5'd31, 4'd12, 14'd0, -13'sd4096);
    send_date(5'd1, 4'd1, 14'd5000, 13'sd4095);
    send_date(5'd31, 4'd1, 14'd5000, -13'sd4096);
    drain_results();
  endtask

  task automatic test_random_dates(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 6) == 0) send_noise_date();
      else                           send_random_date(1'b0);
    end
    drain_results();
  endtask

  // Sink held off while the source keeps offering beats
  task automatic test_output_hold();
    sink_hold = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) send_random_date(1'b0);
    drain_results();
  endtask

  task automatic test_year_limits(input int count);
    for (int i = 0; i < count; i++) send_random_date(1'b1);
    drain_results();
  endtask

  task automatic test_streaming(input int count);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) send_noise_date();
      else                           send_random_date(1'b0);
    end
    drain_results();
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.day         <= '0;
    in_ch.month       <= '0;
    in_ch.year        <= '0;
    in_ch.offset_days <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_calendar_edges();
    test_random_dates(1300);
    test_output_hold();
    test_year_limits(200);
    test_streaming(250);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("calendar_date_add_days_top: match");
    end else begin
      $display("calendar_date_add_days_top: mismatch");
    end
    $finish;
  end

endmodule
